[sv/chi_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_pkg
// Shared types, fault codes and 64-bit saturating helpers for the cubic
// Hermite interpolator.
// ---------------------------------------------------------------------------
package chi_pkg;

	localparam int XW = 64;

	typedef logic signed [XW-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(XW-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(XW-1){1'b0}}};

	typedef enum logic [1:0] {
		FAULT_OK    = 2'd0,
		FAULT_EQUAL = 2'd1,
		FAULT_SAT   = 2'd2
	} fault_t;

	// Value with its saturation flag
	typedef struct packed {
		logic  sat;
		word_t v;
	} sres_t;

	// Working set of one request as it moves down the pipeline
	typedef struct packed {
		word_t f0;
		word_t df0;
		word_t fd;
		word_t dfd;
		word_t dt;
		word_t s;
		word_t u;
		word_t a1;
		word_t q;
		word_t p;
		word_t a2;
		word_t a2x2;
		word_t a3;
		word_t h;
		word_t d;
		logic  eq;
		logic  sat;
	} chi_item_t;

	function automatic sres_t sadd(word_t a, word_t b);
		logic signed [XW:0] s;
		sres_t r;
		s = (XW+1)'(a) + (XW+1)'(b);
		r.sat = s[XW] != s[XW-1];
		r.v = r.sat ? (s[XW] ? WMIN : WMAX) : s[XW-1:0];
		return r;
	endfunction

	function automatic sres_t ssub(word_t a, word_t b);
		logic signed [XW:0] s;
		sres_t r;
		s = (XW+1)'(a) - (XW+1)'(b);
		r.sat = s[XW] != s[XW-1];
		r.v = r.sat ? (s[XW] ? WMIN : WMAX) : s[XW-1:0];
		return r;
	endfunction

	// Apply sign to a magnitude, saturating on overflow
	function automatic sres_t pack(logic hi, logic [XW-1:0] lo, logic neg);
		sres_t r;
		if (neg) begin
			r.sat = hi || (lo > {1'b1, {(XW-1){1'b0}}});
			r.v = r.sat ? WMIN : word_t'({XW{1'b0}} - lo);
		end else begin
			r.sat = hi || lo[XW-1];
			r.v = r.sat ? WMAX : word_t'(lo);
		end
		return r;
	endfunction

	// Clamp to a signed range of w bits
	function automatic sres_t narrow(word_t v, int w);
		word_t hi;
		word_t lo;
		sres_t r;
		hi = (word_t'(1) <<< (w - 1)) - word_t'(1);
		lo = -hi - word_t'(1);
		r.sat = (v > hi) || (v < lo);
		r.v = (v > hi) ? hi : ((v < lo) ? lo : v);
		return r;
	endfunction

endpackage

[sv/chi_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_if
// Valid/ready channels for interpolation requests and results.
// ---------------------------------------------------------------------------
interface chi_query_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] value_start;
	logic signed [W-1:0] value_end;
	logic signed [W-1:0] slope_start;
	logic signed [W-1:0] slope_end;
	logic signed [W-1:0] time_start;
	logic signed [W-1:0] time_end;
	logic signed [W-1:0] time_query;

	modport source(output valid, value_start, value_end, slope_start, slope_end,
		time_start, time_end, time_query, input ready);
	modport sink(input valid, value_start, value_end, slope_start, slope_end,
		time_start, time_end, time_query, output ready);
	// passive view for observers
	modport monitor(input valid, ready, value_start, value_end, slope_start, slope_end,
		time_start, time_end, time_query);
endinterface

interface chi_result_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] interp_value;
	logic signed [W-1:0] interp_slope;
	logic [1:0]          fault;

	modport source(output valid, interp_value, interp_slope, fault, input ready);
	modport sink(input valid, interp_value, interp_slope, fault, output ready);
	// passive view for observers
	modport monitor(input valid, ready, interp_value, interp_slope, fault);
endinterface

[sv/cubic_hermite_interpolator_top.sv]
`timescale 1ns / 1ps
// Depth: most of the pipeline from request to result lies in the two bit-per-stage
//   dividers (72+FRAC_BITS and 64+FRAC_BITS stages).
// Throughput: one request per cycle; a stalled result freezes the whole pipeline.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ---------------------------------------------------------------------------
// cubic_hermite_interpolator_top
// Evaluates a cubic Hermite segment and its slope at a query time, in
// 64-bit saturating fixed point, fully pipelined.
// ---------------------------------------------------------------------------
module cubic_hermite_interpolator_top import chi_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	chi_query_if.sink    query,
	chi_result_if.source result
);

	localparam int U_FRAC = FRAC_BITS + 8;
	localparam int IW     = $bits(chi_item_t);

	logic en;

	// advance everything unless a result waits
	assign en          = !result.valid || result.ready;
	assign query.ready = en;

	// ---- differences of the inputs ----
	chi_item_t s1_d, it_s1;
	logic      v_s1;
	sres_t     r_fd, r_dfd, r_dt, r_s;
	word_t     f1, df1, t0, t1, tq;

	always_comb begin
		s1_d     = '0;
		s1_d.f0  = word_t'(query.value_start);
		s1_d.df0 = word_t'(query.slope_start);
		f1       = word_t'(query.value_end);
		df1      = word_t'(query.slope_end);
		t0       = word_t'(query.time_start);
		t1       = word_t'(query.time_end);
		tq       = word_t'(query.time_query);
		r_fd     = ssub(f1, s1_d.f0);
		r_dfd    = ssub(df1, s1_d.df0);
		r_dt     = ssub(t1, t0);
		r_s      = ssub(tq, t0);
		s1_d.fd  = r_fd.v;
		s1_d.dfd = r_dfd.v;
		s1_d.dt  = r_dt.v;
		s1_d.s   = r_s.v;
		s1_d.eq  = t1 == t0;
		s1_d.sat = r_fd.sat | r_dfd.sat | r_dt.sat | r_s.sat;
	end

	chi_stage #(.PW(IW)) u_s1 (
		.clk, .arst_n, .en, .vin(query.valid), .din(s1_d), .vout(v_s1), .dout(it_s1)
	);

	// ---- normalized position u ----
	logic      v_u;
	sres_t     u_res;
	chi_item_t pay_u, it_u;

	chi_div #(.SH(U_FRAC), .PW(IW)) u_div_u (
		.clk, .arst_n, .en, .vin(v_s1), .num(it_s1.s), .den(it_s1.dt), .pin(it_s1),
		.vout(v_u), .y(u_res), .pout(pay_u)
	);

	always_comb begin
		it_u     = pay_u;
		it_u.u   = u_res.v;
		it_u.sat = pay_u.sat | u_res.sat;
	end

	// ---- a1 = df0*dt, q = (df1-df0)*dt ----
	word_t     ma_a [2];
	word_t     ma_b [2];
	sres_t     ma_y [2];
	logic      v_ma;
	chi_item_t pay_ma, e1_d, it_e1;
	logic      v_e1;
	sres_t     r_p;

	assign ma_a[0] = it_u.df0;
	assign ma_b[0] = it_u.dt;
	assign ma_a[1] = it_u.dfd;
	assign ma_b[1] = it_u.dt;

	chi_mul #(.SH(FRAC_BITS), .LANES(2), .PW(IW)) u_mul_a (
		.clk, .arst_n, .en, .vin(v_u), .a(ma_a), .b(ma_b), .pin(it_u),
		.vout(v_ma), .y(ma_y), .pout(pay_ma)
	);

	// p = (f1 - f0) - a1
	always_comb begin
		e1_d     = pay_ma;
		e1_d.a1  = ma_y[0].v;
		e1_d.q   = ma_y[1].v;
		r_p      = ssub(pay_ma.fd, ma_y[0].v);
		e1_d.p   = r_p.v;
		e1_d.sat = pay_ma.sat | ma_y[0].sat | ma_y[1].sat | r_p.sat;
	end

	chi_stage #(.PW(IW)) u_e1 (
		.clk, .arst_n, .en, .vin(v_ma), .din(e1_d), .vout(v_e1), .dout(it_e1)
	);

	// ---- a2 = 3p - q, one add per stage ----
	chi_item_t e2_d, it_e2, e3_d, it_e3, e4_d, it_e4, e5_d, it_e5;
	logic      v_e2, v_e3, v_e4, v_e5;
	sres_t     r_e2, r_e3, r_e4, r_a3, r_a2x2;

	always_comb begin
		e2_d     = it_e1;
		r_e2     = sadd(it_e1.p, it_e1.p);
		e2_d.a2  = r_e2.v;
		e2_d.sat = it_e1.sat | r_e2.sat;
	end

	chi_stage #(.PW(IW)) u_e2 (
		.clk, .arst_n, .en, .vin(v_e1), .din(e2_d), .vout(v_e2), .dout(it_e2)
	);

	always_comb begin
		e3_d     = it_e2;
		r_e3     = sadd(it_e2.a2, it_e2.p);
		e3_d.a2  = r_e3.v;
		e3_d.sat = it_e2.sat | r_e3.sat;
	end

	chi_stage #(.PW(IW)) u_e3 (
		.clk, .arst_n, .en, .vin(v_e2), .din(e3_d), .vout(v_e3), .dout(it_e3)
	);

	always_comb begin
		e4_d     = it_e3;
		r_e4     = ssub(it_e3.a2, it_e3.q);
		e4_d.a2  = r_e4.v;
		e4_d.sat = it_e3.sat | r_e4.sat;
	end

	chi_stage #(.PW(IW)) u_e4 (
		.clk, .arst_n, .en, .vin(v_e3), .din(e4_d), .vout(v_e4), .dout(it_e4)
	);

	// a3 = p - a2, and 2*a2 for the slope
	always_comb begin
		e5_d      = it_e4;
		r_a3      = ssub(it_e4.p, it_e4.a2);
		r_a2x2    = sadd(it_e4.a2, it_e4.a2);
		e5_d.a3   = r_a3.v;
		e5_d.a2x2 = r_a2x2.v;
		e5_d.sat  = it_e4.sat | r_a3.sat | r_a2x2.sat;
	end

	chi_stage #(.PW(IW)) u_e5 (
		.clk, .arst_n, .en, .vin(v_e4), .din(e5_d), .vout(v_e5), .dout(it_e5)
	);

	// ---- 3*a3 for the slope ----
	chi_item_t x1_d, it_x1, x2_d, it_x2;
	logic      v_x1, v_x2;
	sres_t     r_x1, r_x2;

	always_comb begin
		x1_d     = it_e5;
		r_x1     = sadd(it_e5.a3, it_e5.a3);
		x1_d.d   = r_x1.v;
		x1_d.sat = it_e5.sat | r_x1.sat;
	end

	chi_stage #(.PW(IW)) u_x1 (
		.clk, .arst_n, .en, .vin(v_e5), .din(x1_d), .vout(v_x1), .dout(it_x1)
	);

	always_comb begin
		x2_d     = it_x1;
		r_x2     = sadd(it_x1.d, it_x1.a3);
		x2_d.d   = r_x2.v;
		x2_d.sat = it_x1.sat | r_x2.sat;
	end

	chi_stage #(.PW(IW)) u_x2 (
		.clk, .arst_n, .en, .vin(v_x1), .din(x2_d), .vout(v_x2), .dout(it_x2)
	);

	// ---- first Horner step: a2 + u*a3, 2a2 + u*3a3 ----
	word_t     m1_a [2];
	word_t     m1_b [2];
	sres_t     m1_y [2];
	logic      v_m1, v_h1;
	chi_item_t pay_m1, h1_d, it_h1;
	sres_t     r_h1, r_d1;

	assign m1_a[0] = it_x2.u;
	assign m1_b[0] = it_x2.a3;
	assign m1_a[1] = it_x2.u;
	assign m1_b[1] = it_x2.d;

	chi_mul #(.SH(U_FRAC), .LANES(2), .PW(IW)) u_mul_1 (
		.clk, .arst_n, .en, .vin(v_x2), .a(m1_a), .b(m1_b), .pin(it_x2),
		.vout(v_m1), .y(m1_y), .pout(pay_m1)
	);

	always_comb begin
		h1_d     = pay_m1;
		r_h1     = sadd(pay_m1.a2, m1_y[0].v);
		r_d1     = sadd(pay_m1.a2x2, m1_y[1].v);
		h1_d.h   = r_h1.v;
		h1_d.d   = r_d1.v;
		h1_d.sat = pay_m1.sat | m1_y[0].sat | m1_y[1].sat | r_h1.sat | r_d1.sat;
	end

	chi_stage #(.PW(IW)) u_h1 (
		.clk, .arst_n, .en, .vin(v_m1), .din(h1_d), .vout(v_h1), .dout(it_h1)
	);

	// ---- second Horner step: a1 + u*h, a1 + u*d ----
	word_t     m2_a [2];
	word_t     m2_b [2];
	sres_t     m2_y [2];
	logic      v_m2, v_h2;
	chi_item_t pay_m2, h2_d, it_h2;
	sres_t     r_h2, r_d2;

	assign m2_a[0] = it_h1.u;
	assign m2_b[0] = it_h1.h;
	assign m2_a[1] = it_h1.u;
	assign m2_b[1] = it_h1.d;

	chi_mul #(.SH(U_FRAC), .LANES(2), .PW(IW)) u_mul_2 (
		.clk, .arst_n, .en, .vin(v_h1), .a(m2_a), .b(m2_b), .pin(it_h1),
		.vout(v_m2), .y(m2_y), .pout(pay_m2)
	);

	always_comb begin
		h2_d     = pay_m2;
		r_h2     = sadd(pay_m2.a1, m2_y[0].v);
		r_d2     = sadd(pay_m2.a1, m2_y[1].v);
		h2_d.h   = r_h2.v;
		h2_d.d   = r_d2.v;
		h2_d.sat = pay_m2.sat | m2_y[0].sat | m2_y[1].sat | r_h2.sat | r_d2.sat;
	end

	chi_stage #(.PW(IW)) u_h2 (
		.clk, .arst_n, .en, .vin(v_m2), .din(h2_d), .vout(v_h2), .dout(it_h2)
	);

	// ---- last value step: f0 + u*h ----
	word_t     m3_a [1];
	word_t     m3_b [1];
	sres_t     m3_y [1];
	logic      v_m3, v_h3;
	chi_item_t pay_m3, h3_d, it_h3;
	sres_t     r_h3;

	assign m3_a[0] = it_h2.u;
	assign m3_b[0] = it_h2.h;

	chi_mul #(.SH(U_FRAC), .LANES(1), .PW(IW)) u_mul_3 (
		.clk, .arst_n, .en, .vin(v_h2), .a(m3_a), .b(m3_b), .pin(it_h2),
		.vout(v_m3), .y(m3_y), .pout(pay_m3)
	);

	always_comb begin
		h3_d     = pay_m3;
		r_h3     = sadd(pay_m3.f0, m3_y[0].v);
		h3_d.h   = r_h3.v;
		h3_d.sat = pay_m3.sat | m3_y[0].sat | r_h3.sat;
	end

	chi_stage #(.PW(IW)) u_h3 (
		.clk, .arst_n, .en, .vin(v_m3), .din(h3_d), .vout(v_h3), .dout(it_h3)
	);

	// ---- slope divided by dt ----
	logic      v_d;
	sres_t     d_res;
	chi_item_t pay_d;

	chi_div #(.SH(FRAC_BITS), .PW(IW)) u_div_d (
		.clk, .arst_n, .en, .vin(v_h3), .num(it_h3.d), .den(it_h3.dt), .pin(it_h3),
		.vout(v_d), .y(d_res), .pout(pay_d)
	);

	// ---- narrow, pick the equal-times case, hold the result ----
	sres_t                  n_val, n_slo;
	logic                   out_v_q;
	logic [DATA_WIDTH-1:0]  val_q, slo_q;
	fault_t                 fault_q;

	always_comb begin
		n_val = narrow(pay_d.h, DATA_WIDTH);
		n_slo = narrow(d_res.v, DATA_WIDTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pay_d.eq) begin
				val_q   <= pay_d.f0[DATA_WIDTH-1:0];
				slo_q   <= pay_d.df0[DATA_WIDTH-1:0];
				fault_q <= FAULT_EQUAL;
			end else begin
				val_q   <= n_val.v[DATA_WIDTH-1:0];
				slo_q   <= n_slo.v[DATA_WIDTH-1:0];
				fault_q <= (pay_d.sat | d_res.sat | n_val.sat | n_slo.sat) ?
					FAULT_SAT : FAULT_OK;
			end
		end
	end

	assign result.valid        = out_v_q;
	assign result.interp_value = val_q;
	assign result.interp_slope = slo_q;
	assign result.fault        = fault_q;

	// ---- checks ----
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		query.ready == (!result.valid || result.ready))
		else $error("ready does not follow the output register");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result.valid)
		else $error("result valid straight out of reset");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !v_d) |=> !result.valid)
		else $error("result repeated after it was taken");

endmodule

[sv/chi_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_stage
// One pipeline register with its valid bit, frozen while en is low.
// ---------------------------------------------------------------------------
module chi_stage #(
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [PW-1:0] din,
	output logic          vout,
	output logic [PW-1:0] dout
);

	logic          vld_s1;
	logic [PW-1:0] dat_s1;

	// advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vin;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= din;
		end
	end

	assign vout = vld_s1;
	assign dout = dat_s1;

endmodule

[sv/chi_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_mul
// Pipelined signed 64x64 fixed-point multiplier, round(a*b / 2^SH) with
// saturation. Five stages: magnitude, 32x32 partial products, middle sum,
// full sum with rounding, shift and sign.
// ---------------------------------------------------------------------------
module chi_mul import chi_pkg::*; #(
	parameter int SH    = 16,
	parameter int LANES = 1,
	parameter int PW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  word_t         a [LANES],
	input  word_t         b [LANES],
	input  logic [PW-1:0] pin,
	output logic          vout,
	output sres_t         y [LANES],
	output logic [PW-1:0] pout
);

	localparam logic [2*XW-1:0] RND = (2*XW)'(1) << (SH - 1);

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PW-1:0] p_s1, p_s2, p_s3, p_s4, p_s5;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// carry payload alongside
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pin;
			p_s2 <= p_s1;
			p_s3 <= p_s2;
			p_s4 <= p_s3;
			p_s5 <= p_s4;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [XW-1:0]   xm_s1, ym_s1;
		logic            neg_s1, neg_s2, neg_s3, neg_s4;
		logic [XW-1:0]   pp0_s2, pp1_s2, pp2_s2, pp3_s2;
		logic [2*XW-1:0] lh_s3;
		logic [XW:0]     mid_s3;
		logic [2*XW-1:0] sum_s4;
		sres_t           y_s5;

		always_ff @(posedge clk) begin
			if (en) begin
				// take magnitudes
				xm_s1  <= a[l][XW-1] ? ({XW{1'b0}} - a[l]) : a[l];
				ym_s1  <= b[l][XW-1] ? ({XW{1'b0}} - b[l]) : b[l];
				neg_s1 <= a[l][XW-1] ^ b[l][XW-1];
				// form partial products
				pp0_s2 <= xm_s1[31:0]  * ym_s1[31:0];
				pp1_s2 <= xm_s1[31:0]  * ym_s1[63:32];
				pp2_s2 <= xm_s1[63:32] * ym_s1[31:0];
				pp3_s2 <= xm_s1[63:32] * ym_s1[63:32];
				neg_s2 <= neg_s1;
				// sum cross terms
				lh_s3  <= {pp3_s2, pp0_s2};
				mid_s3 <= {1'b0, pp1_s2} + {1'b0, pp2_s2};
				neg_s3 <= neg_s2;
				// full product plus rounding half
				sum_s4 <= lh_s3 + {31'd0, mid_s3, 32'd0} + RND;
				neg_s4 <= neg_s3;
				// shift and apply sign
				y_s5   <= pack(|sum_s4[2*XW-1:XW+SH], sum_s4[SH+XW-1:SH], neg_s4);
			end
		end

		assign y[l] = y_s5;
	end

	assign vout = v_s5;
	assign pout = p_s5;

endmodule

[sv/chi_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_div
// Pipelined signed divider, round(num * 2^SH / den) with saturation.
// Restoring division, one quotient bit per stage over 64+SH stages,
// framed by a magnitude stage and a rounding stage.
// ---------------------------------------------------------------------------
module chi_div import chi_pkg::*; #(
	parameter int SH = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  word_t         num,
	input  word_t         den,
	input  logic [PW-1:0] pin,
	output logic          vout,
	output sres_t         y,
	output logic [PW-1:0] pout
);

	localparam int N = XW + SH;

	logic          v_s   [0:N];
	logic [PW-1:0] pay_s [0:N];
	logic [N-1:0]  dvd_s [0:N];
	logic [XW-1:0] den_s [0:N];
	logic [XW-1:0] rem_s [0:N];
	logic [XW-1:0] quo_s [0:N];
	logic          ovf_s [0:N];
	logic          neg_s [0:N];

	logic          v_out_q;
	logic [PW-1:0] pay_out_q;
	sres_t         y_q;
	logic          rnd;
	logic [XW:0]   qr;

	// take magnitudes and align the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= pin;
			dvd_s[0] <= {(num[XW-1] ? ({XW{1'b0}} - num) : num), {SH{1'b0}}};
			den_s[0] <= den[XW-1] ? ({XW{1'b0}} - den) : den;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			ovf_s[0] <= 1'b0;
			neg_s[0] <= num[XW-1] ^ den[XW-1];
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [XW:0] trial;
		logic [XW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], dvd_s[k][N-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[k+1] <= pay_s[k];
				dvd_s[k+1] <= {dvd_s[k][N-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= ge ? diff[XW-1:0] : trial[XW-1:0];
				quo_s[k+1] <= {quo_s[k][XW-2:0], ge};
				ovf_s[k+1] <= ovf_s[k] | quo_s[k][XW-1];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// round half away from zero and apply sign
	always_comb begin
		rnd = {rem_s[N], 1'b0} >= {1'b0, den_s[N]};
		qr  = {1'b0, quo_s[N]} + (XW+1)'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_out_q <= pay_s[N];
			y_q       <= pack(ovf_s[N] | qr[XW], qr[XW-1:0], neg_s[N]);
		end
	end

	assign vout = v_out_q;
	assign pout = pay_out_q;
	assign y    = y_q;

endmodule

[verif/chi_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chi_checker
// Watches the request and result channels of the cubic Hermite interpolator,
// computes the expected value, slope and fault code of every accepted request
// in 64-bit saturating fixed point, and compares each result in order.
// ---------------------------------------------------------------------------
module chi_checker import chi_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	chi_query_if.monitor  query,
	chi_result_if.monitor result,
	output int           errors,
	output int           pending,
	output int           results_seen,
	output int           sat_seen,
	output int           equal_seen
);

	localparam int U_FRAC = FRAC_BITS + 8;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] value;
		logic signed [DATA_WIDTH-1:0] slope;
		fault_t                       fault;
	} interp_t;

	interp_t expected_q[$];
	logic    ovf;

	assign pending = expected_q.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic word_t add_s(word_t a, word_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin ovf = 1; return WMAX; end
		if (s < -65'sh0_8000_0000_0000_0000) begin ovf = 1; return WMIN; end
		return s[63:0];
	endfunction

	function automatic word_t sub_s(word_t a, word_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin ovf = 1; return WMAX; end
		if (s < -65'sh0_8000_0000_0000_0000) begin ovf = 1; return WMIN; end
		return s[63:0];
	endfunction

	// Sign a 192-bit magnitude back into 64 bits, clamping on overflow
	function automatic word_t signed_fit(logic [191:0] mag, logic neg);
		if (neg) begin
			if (mag > 192'h8000_0000_0000_0000) begin ovf = 1; return WMIN; end
			return word_t'(-mag[63:0]);
		end
		if (mag > 192'h7FFF_FFFF_FFFF_FFFF) begin ovf = 1; return WMAX; end
		return word_t'(mag[63:0]);
	endfunction

	function automatic logic [63:0] mag_of(word_t a);
		return a[63] ? -a : a;
	endfunction

	// round(a*b / 2^sh), ties away from zero
	function automatic word_t mul_round(word_t a, word_t b, int sh);
		logic [191:0] p;
		p = {128'd0, mag_of(a)} * {128'd0, mag_of(b)};
		if (sh > 0) p = (p + (192'd1 << (sh - 1))) >> sh;
		return signed_fit(p, a[63] ^ b[63]);
	endfunction

	// round(num * 2^sh / den), ties away from zero
	function automatic word_t div_round(word_t num, word_t den, int sh);
		logic [191:0] n, d, q, r;
		n = {128'd0, mag_of(num)} << sh;
		d = {128'd0, mag_of(den)};
		q = n / d;
		r = n % d;
		if (r >= d - r) q++;
		return signed_fit(q, num[63] ^ den[63]);
	endfunction

	function automatic word_t clamp_dw(word_t v);
		word_t hi, lo;
		hi = (word_t'(1) <<< (DATA_WIDTH - 1)) - word_t'(1);
		lo = -hi - word_t'(1);
		if (v > hi) begin ovf = 1; return hi; end
		if (v < lo) begin ovf = 1; return lo; end
		return v;
	endfunction

	function automatic interp_t hermite_eval(word_t f0, word_t f1, word_t df0, word_t df1,
			word_t t0, word_t t1, word_t t);
		interp_t r;
		word_t dt, s, u, a1, p, q, a2, a3, h, d, vc, sc;
		ovf = 0;
		if (t1 == t0) begin
			r.value = f0[DATA_WIDTH-1:0];
			r.slope = df0[DATA_WIDTH-1:0];
			r.fault = FAULT_EQUAL;
			return r;
		end
		dt = sub_s(t1, t0);
		s  = sub_s(t, t0);
		u  = div_round(s, dt, U_FRAC);
		a1 = mul_round(df0, dt, FRAC_BITS);
		p  = sub_s(sub_s(f1, f0), a1);
		q  = mul_round(sub_s(df1, df0), dt, FRAC_BITS);
		a2 = sub_s(add_s(add_s(p, p), p), q);
		a3 = sub_s(p, a2);
		h  = add_s(a2, mul_round(u, a3, U_FRAC));
		h  = add_s(a1, mul_round(u, h, U_FRAC));
		h  = add_s(f0, mul_round(u, h, U_FRAC));
		d  = add_s(add_s(a3, a3), a3);
		d  = add_s(add_s(a2, a2), mul_round(u, d, U_FRAC));
		d  = add_s(a1, mul_round(u, d, U_FRAC));
		d  = div_round(d, dt, FRAC_BITS);
		vc = clamp_dw(h);
		sc = clamp_dw(d);
		r.value = vc[DATA_WIDTH-1:0];
		r.slope = sc[DATA_WIDTH-1:0];
		r.fault = ovf ? FAULT_SAT : FAULT_OK;
		return r;
	endfunction

	// Predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		interp_t exp_r;
		if (!arst_n) begin
			expected_q.delete();
			errors = 0;
			results_seen = 0;
			sat_seen = 0;
			equal_seen = 0;
		end else begin
			if (query.valid && query.ready)
				expected_q.push_back(hermite_eval(query.value_start, query.value_end,
					query.slope_start, query.slope_end, query.time_start,
					query.time_end, query.time_query));
			if (result.valid && result.ready) begin
				results_seen++;
				if (result.fault == FAULT_SAT) sat_seen++;
				if (result.fault == FAULT_EQUAL) equal_seen++;
				if (expected_q.size() == 0) begin
					report("unexpected result", 64'(result.interp_value), 64'd0);
				end else begin
					exp_r = expected_q.pop_front();
					if (result.interp_value !== exp_r.value)
						report("interp_value", 64'(result.interp_value), 64'(exp_r.value));
					if (result.interp_slope !== exp_r.slope)
						report("interp_slope", 64'(result.interp_slope), 64'(exp_r.slope));
					if (result.fault !== exp_r.fault)
						report("fault", 64'(result.fault), 64'(exp_r.fault));
				end
			end
		end
	end

endmodule

[verif/cubic_hermite_interpolator_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_hermite_interpolator_top_tb
// Drives directed corner requests and random segments into the interpolator
// under varying valid/ready idling and one long result stall; a checker
// module predicts and compares every result.
// ---------------------------------------------------------------------------
module cubic_hermite_interpolator_top_tb import chi_pkg::*;;

	localparam int W = 32;

	logic clk;
	logic arst_n;
	int   errors, pending, results_seen, sat_seen, equal_seen;
	int   src_idle_pct, dst_idle_pct;
	int   hold_off;
	int   sent;

	chi_query_if  #(W) query();
	chi_result_if #(W) result();

	cubic_hermite_interpolator_top #(.DATA_WIDTH(W), .FRAC_BITS(16)) u_top (
		.clk(clk), .arst_n(arst_n), .query(query.sink), .result(result.source)
	);

	chi_checker #(.DATA_WIDTH(W), .FRAC_BITS(16)) u_checker (
		.clk(clk), .arst_n(arst_n), .query(query.monitor), .result(result.monitor),
		.errors(errors), .pending(pending), .results_seen(results_seen),
		.sat_seen(sat_seen), .equal_seen(equal_seen)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Receiver: random idling, or a counted hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// Offer one request and hold it until accepted
	task automatic send(input logic [W-1:0] f0, f1, df0, df1, t0, t1, t);
		while ($urandom_range(99) < src_idle_pct) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.valid <= 1'b1;
		query.value_start <= f0;
		query.value_end <= f1;
		query.slope_start <= df0;
		query.slope_end <= df1;
		query.time_start <= t0;
		query.time_end <= t1;
		query.time_query <= t;
		@(posedge clk);
		while (!query.ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [W-1:0] rnd_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
		endcase
	endfunction

	// Random segment: moderate data half the time, mostly with a sensible interval
	task automatic send_random();
		logic [W-1:0] t0, t1, t;
		t0 = 32'($signed($urandom_range(200 << 16)) - (100 << 16));
		t1 = t0 + 32'($urandom_range(50 << 16) + 1);
		if ($urandom_range(9) == 0) t1 = t0 - 32'($urandom_range(1 << 16) + 1);
		if ($urandom_range(19) == 0) t1 = t0;
		t = t0 + 32'($signed($urandom_range(32'(t1 - t0) * 2)) - $signed(32'(t1 - t0)) / 2);
		if ($urandom_range(9) == 0) begin
			send(rnd_word(), rnd_word(), rnd_word(), rnd_word(), $urandom(), $urandom(),
				$urandom());
		end else begin
			send(rnd_word(), rnd_word(), rnd_word(), rnd_word(), t0, t1, t);
		end
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		#20_000_000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		hold_off = 0;
		sent = 0;
		src_idle_pct = 14;
		dst_idle_pct = 58;
		query.valid = 1'b0;
		query.value_start = '0;
		query.value_end = '0;
		query.slope_start = '0;
		query.slope_end = '0;
		query.time_start = '0;
		query.time_end = '0;
		query.time_query = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: equal times, extremes, ends of interval, saturation
		send(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h7FFF_FFFF,
			32'h0003_0000, 32'h0003_0000, 32'h0005_0000);
		send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send(32'h0001_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		send(32'h0001_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
		send(32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000,
			32'h0000_0000, 32'h0002_0000, 32'h0001_0000);
		send(32'hFFFF_0000, 32'h0004_0000, 32'h0001_8000, 32'h0000_4000,
			32'hFFFE_0000, 32'h0003_0000, 32'h0007_0000);
		send(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0001_0000, 32'h0000_0000, 32'h0000_8000);
		send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
		send(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0000_0000, 32'h0000_0003, 32'h0000_0001);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0001, 32'h0000_0000);

		// Random with sender 14 / receiver 58 percent idle
		repeat (230) send_random();
		// Long receiver stall while requests keep coming
		hold_off <= 600;
		repeat (300) send_random();
		src_idle_pct = 58;
		dst_idle_pct = 14;
		repeat (120) send_random();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		repeat (80) send_random();
		query.valid <= 1'b0;

		drain();
		repeat (300) @(posedge clk);
		$display("run covered %0d requests, %0d results (%0d saturated, %0d equal times)",
			sent, results_seen, sat_seen, equal_seen);
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
